// ===== sv/macroblock_raster_pixel_packer_macros.svh =====
// Assertion macros for the macroblock raster pixel packer.
// Each macro wraps one concurrent check, clocked on the rising edge and
// disabled while reset is active.
`ifndef MACROBLOCK_RASTER_PIXEL_PACKER_MACROS_SVH
`define MACROBLOCK_RASTER_PIXEL_PACKER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define MRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrp assertion failed");

// Next-cycle implication.
`define MRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrp assertion failed");

`else

`define MRP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg - shared types and constants
// Field widths, pixel formats, register indexes and stage payload structs.
// ----------------------------------------------------------------------------
package mrp_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned BLOCK_SIDE = 16;

    localparam int unsigned COMP_W   = 8;
    localparam int unsigned WIDTH_W  = 13;
    localparam int unsigned BUF_W    = 27;
    localparam int unsigned ADDR_W   = 26;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned DATA_W   = 27;
    localparam int unsigned LINE_W   = 12;   // raster row / column
    localparam int unsigned OFFS_W   = 25;   // row * width + column
    localparam int unsigned SCALED_W = 27;   // offset times bytes per pixel

    localparam logic [BUF_W-1:0] ADDR_SPAN = BUF_W'(1) << ADDR_W;

    typedef enum logic [1:0] {
        FMT_BGR888   = 2'd0,
        FMT_BGRA8888 = 2'd1,
        FMT_GRAY8    = 2'd2,
        FMT_RGB565   = 2'd3
    } fmt_t;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_PIXEL_FORMAT = 2'd1,
        REG_BUFFER_SIZE  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    localparam logic [COUNT_W-1:0] N_GRAY8  = 3'd1;
    localparam logic [COUNT_W-1:0] N_RGB565 = 3'd2;
    localparam logic [COUNT_W-1:0] N_BGR888 = 3'd3;
    localparam logic [COUNT_W-1:0] N_BGRA   = 3'd4;

    // Effective configuration, already clamped.
    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        fmt_t               fmt;
        logic [BUF_W-1:0]   limit;
    } cfg_t;

    typedef struct packed {
        logic [COMP_W-1:0] block_x;
        logic [COMP_W-1:0] block_y;
        logic [COMP_W-1:0] pixel_index;
        logic [COMP_W-1:0] red_or_gray;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] alpha;
    } pix_t;

    typedef struct packed {
        logic [OFFS_W-1:0]          offset;
        logic [COUNT_W-1:0]         n;
        logic [3:0][COMP_W-1:0]     bytes;
    } mid_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  byte_address;
        logic [COUNT_W-1:0] byte_count;
        logic [3:0][COMP_W-1:0] bytes;
    } res_t;

endpackage

// ===== sv/mrp_ifs.sv =====
// ----------------------------------------------------------------------------
// mrp_ifs - channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface mrp_pix_if;
    import mrp_pkg::*;
    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] block_x;
    logic [COMP_W-1:0] block_y;
    logic [COMP_W-1:0] pixel_index;
    logic [COMP_W-1:0] red_or_gray;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] alpha;

    modport source (output valid, block_x, block_y, pixel_index, red_or_gray,
                    green, blue, alpha, input ready);
    modport sink   (input valid, block_x, block_y, pixel_index, red_or_gray,
                    green, blue, alpha, output ready);
endinterface

interface mrp_res_if;
    import mrp_pkg::*;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  byte_address;
    logic [COUNT_W-1:0] byte_count;
    logic [COMP_W-1:0]  out_byte0;
    logic [COMP_W-1:0]  out_byte1;
    logic [COMP_W-1:0]  out_byte2;
    logic [COMP_W-1:0]  out_byte3;

    modport source (output valid, byte_address, byte_count, out_byte0, out_byte1,
                    out_byte2, out_byte3, input ready);
    modport sink   (input valid, byte_address, byte_count, out_byte0, out_byte1,
                    out_byte2, out_byte3, output ready);
endinterface

interface mrp_cfg_if;
    import mrp_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/macroblock_raster_pixel_packer.sv =====
// ----------------------------------------------------------------------------
// macroblock_raster_pixel_packer - macroblock pixel to raster byte packer
// One request per cycle while the result side takes results; a stall backs up the input.
// Rate set by the single 12x13 offset multiplier stage, fully pipelined.
// Async active-low reset empties the pipe and loads register defaults.
// ----------------------------------------------------------------------------
//
// Pipeline:
//   stage 1  pixel input register
//   stage 2  raster offset: (block_y*16 + index/16) * width + block_x*16 + index%16,
//            plus format packing into up to four bytes
//   stage 3  offset scaled by bytes per pixel (1..4), compared with the
//            clamped buffer size; count trimmed at the buffer end and unused
//            bytes zeroed; result register
// Each stage refills while the one after it drains, so a stalled result
// still lets two more requests enter before the input backs up.
// Configuration writes are taken every cycle and go straight to the register file;
// the user must issue them only while the pipe is empty; the block does not check it.
module macroblock_raster_pixel_packer (
    input  logic   clk,
    input  logic   rst_n,
    mrp_cfg_if.sink    cfg,
    mrp_pix_if.sink    pixels,
    mrp_res_if.source  results
);
    import mrp_pkg::*;

    cfg_t  cfg_eff;
    pix_t  in_pix;
    logic  mid_valid;
    logic  mid_ready;
    mid_t  mid;
    res_t  res;

    // register file always takes the write
    assign cfg.ready = 1'b1;

    mrp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_eff)
    );

    always_comb
    begin
        in_pix.block_x     = pixels.block_x;
        in_pix.block_y     = pixels.block_y;
        in_pix.pixel_index = pixels.pixel_index;
        in_pix.red_or_gray = pixels.red_or_gray;
        in_pix.green       = pixels.green;
        in_pix.blue        = pixels.blue;
        in_pix.alpha       = pixels.alpha;
    end

    mrp_offset_stage u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_eff),
        .in_valid  (pixels.valid),
        .in_pix    (in_pix),
        .in_ready  (pixels.ready),
        .mid_valid (mid_valid),
        .mid       (mid),
        .mid_ready (mid_ready)
    );

    mrp_emit_stage u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_eff),
        .mid_valid (mid_valid),
        .mid       (mid),
        .mid_ready (mid_ready),
        .res_valid (results.valid),
        .res       (res),
        .res_ready (results.ready)
    );

    assign results.byte_address = res.byte_address;
    assign results.byte_count   = res.byte_count;
    assign results.out_byte0    = res.bytes[0];
    assign results.out_byte1    = res.bytes[1];
    assign results.out_byte2    = res.bytes[2];
    assign results.out_byte3    = res.bytes[3];

endmodule

// ===== sv/mrp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mrp_cfg_regs - configuration register file
// Holds width, format and buffer size; presents clamped values.
// ----------------------------------------------------------------------------
module mrp_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [mrp_pkg::IDX_W-1:0]   wr_index,
    input  logic [mrp_pkg::DATA_W-1:0]  wr_data,
    output mrp_pkg::cfg_t               cfg
);
    import mrp_pkg::*;

    logic [WIDTH_W-1:0] width_reg;
    fmt_t               fmt_reg;
    logic [BUF_W-1:0]   bufsize_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_W'(1);
            fmt_reg     <= FMT_BGR888;
            bufsize_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_IMAGE_WIDTH:  width_reg   <= wr_data[WIDTH_W-1:0];
                REG_PIXEL_FORMAT: fmt_reg     <= fmt_t'(wr_data[1:0]);
                REG_BUFFER_SIZE:  bufsize_reg <= wr_data[BUF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.width = (width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_reg;
        cfg.fmt   = fmt_reg;
        cfg.limit = (bufsize_reg > ADDR_SPAN) ? ADDR_SPAN : bufsize_reg;
    end

endmodule

// ===== sv/mrp_offset_stage.sv =====
// ----------------------------------------------------------------------------
// mrp_offset_stage - input register and raster offset stage
// Registers the pixel, then forms row * width + column and the packed bytes.
// ----------------------------------------------------------------------------
module mrp_offset_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  mrp_pkg::cfg_t  cfg,
    input  logic           in_valid,
    input  mrp_pkg::pix_t  in_pix,
    output logic           in_ready,
    output logic           mid_valid,
    output mrp_pkg::mid_t  mid,
    input  logic           mid_ready
);
    import mrp_pkg::*;

    logic  pix_valid_reg;
    pix_t  pix_reg;
    logic  mid_valid_reg;
    mid_t  mid_reg;
    mid_t  mid_next;
    logic  pix_ready;

    logic [LINE_W-1:0] row;
    logic [LINE_W-1:0] col;

    assign pix_ready = !mid_valid_reg || mid_ready;
    assign in_ready  = !pix_valid_reg || pix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                pix_valid_reg <= in_valid;
            if (pix_ready)
                mid_valid_reg <= pix_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            pix_reg <= in_pix;
        if (pix_ready && pix_valid_reg)
            mid_reg <= mid_next;
    end

    always_comb
    begin
        // 16 pixels per block row: index splits into row and column nibbles
        row = {pix_reg.block_y, pix_reg.pixel_index[7:4]};
        col = {pix_reg.block_x, pix_reg.pixel_index[3:0]};
        mid_next.offset = OFFS_W'(row) * OFFS_W'(cfg.width) + OFFS_W'(col);
        mid_next.bytes  = '0;
        unique case (cfg.fmt)
            FMT_BGR888:
            begin
                mid_next.n        = N_BGR888;
                mid_next.bytes[0] = pix_reg.blue;
                mid_next.bytes[1] = pix_reg.green;
                mid_next.bytes[2] = pix_reg.red_or_gray;
            end
            FMT_BGRA8888:
            begin
                mid_next.n        = N_BGRA;
                mid_next.bytes[0] = pix_reg.blue;
                mid_next.bytes[1] = pix_reg.green;
                mid_next.bytes[2] = pix_reg.red_or_gray;
                mid_next.bytes[3] = pix_reg.alpha;
            end
            FMT_GRAY8:
            begin
                mid_next.n        = N_GRAY8;
                mid_next.bytes[0] = pix_reg.red_or_gray;
            end
            default:
            begin
                // blue is not masked to five bits
                mid_next.n        = N_RGB565;
                mid_next.bytes[0] = {pix_reg.green[2:0], 5'b0} | pix_reg.blue;
                mid_next.bytes[1] = {pix_reg.red_or_gray[4:0], pix_reg.green[5:3]};
            end
        endcase
    end

    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

endmodule

// ===== sv/mrp_emit_stage.sv =====
// ----------------------------------------------------------------------------
// mrp_emit_stage - byte scaling, buffer clipping and result register
// Scales the offset by bytes per pixel and trims the count at buffer end.
// ----------------------------------------------------------------------------
`include "macroblock_raster_pixel_packer_macros.svh"

module mrp_emit_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  mrp_pkg::cfg_t  cfg,
    input  logic           mid_valid,
    input  mrp_pkg::mid_t  mid,
    output logic           mid_ready,
    output logic           res_valid,
    output mrp_pkg::res_t  res,
    input  logic           res_ready
);
    import mrp_pkg::*;

    logic  res_valid_reg;
    res_t  res_reg;
    res_t  res_next;

    logic [SCALED_W-1:0] addr;
    logic [BUF_W-1:0]    room;
    logic                in_range;
    logic [COUNT_W-1:0]  count;

    assign mid_ready = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (mid_ready)
            res_valid_reg <= mid_valid;
    end

    always_ff @(posedge clk)
    begin
        if (mid_ready && mid_valid)
            res_reg <= res_next;
    end

    always_comb
    begin
        case (mid.n)
            N_GRAY8:  addr = SCALED_W'(mid.offset);
            N_RGB565: addr = SCALED_W'(mid.offset) << 1;
            N_BGR888: addr = (SCALED_W'(mid.offset) << 1) + SCALED_W'(mid.offset);
            default:  addr = SCALED_W'(mid.offset) << 2;
        endcase
        in_range = addr < cfg.limit;
        room     = cfg.limit - addr;
        if (!in_range)
            count = '0;
        else if (room > BUF_W'(mid.n))
            count = mid.n;
        else
            count = room[COUNT_W-1:0];

        res_next.byte_address = in_range ? addr[ADDR_W-1:0] : '0;
        res_next.byte_count   = count;
        for (int k = 0; k < 4; k++)
            res_next.bytes[k] = (COUNT_W'(k) < count) ? mid.bytes[k] : '0;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `MRP_ASSERT_IMPL(a_drop_is_blank, clk, rst_n, res_valid_reg && res_reg.byte_count == '0, res_reg.byte_address == '0 && res_reg.bytes == '0)
    `MRP_ASSERT_IMPL(a_count_in_buffer, clk, rst_n, res_valid_reg && res_reg.byte_count != '0, BUF_W'(res_reg.byte_address) < cfg.limit)
    `MRP_ASSERT_IMPL(a_tail_zero, clk, rst_n, res_valid_reg && res_reg.byte_count < N_BGRA, res_reg.bytes[3] == '0)
    `MRP_ASSERT_NEXT(a_stall_holds, clk, rst_n, res_valid_reg && !res_ready, res_valid_reg && $stable(res_reg))

endmodule

// ===== verif/tb_macroblock_raster_pixel_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_macroblock_raster_pixel_packer - pixel packer testbench
// Drives macroblock pixels through the packer under several register settings
// and idle/stall mixes. Each result is checked field by field against a
// scoreboard that this bench predicts from the pixel and the shadow registers.
// ----------------------------------------------------------------------------
module tb_macroblock_raster_pixel_packer;
    import mrp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
    localparam int PIPE_SETTLE = 4;        // three pipeline stages plus margin

    typedef longint unsigned u64_t;

    logic clk;
    logic rst_n;

    mrp_cfg_if cfg_bus ();
    mrp_pix_if pix_bus ();
    mrp_res_if res_bus ();

    macroblock_raster_pixel_packer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .pixels  (pix_bus),
        .results (res_bus)
    );

    // Shadow copy of the register file, updated on each accepted write.
    logic [WIDTH_W-1:0] width_reg;
    fmt_t               fmt_reg;
    logic [BUF_W-1:0]   bufsz_reg;

    // Packed results still owed by the block, oldest first.
    res_t pending_pixels[$];

    int errors = 0;
    int cycle_cnt = 0;
    int idle_pct;     // chance in 100 that the pixel source idles a cycle
    int stall_pct;    // chance in 100 that the result sink stalls a cycle

    // ------------------------------------------------------------------
    // Clock, cycle watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_macroblock_raster_pixel_packer: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic u64_t bytes_per_pixel(fmt_t f);
        case (f)
            FMT_BGR888:   return 3;
            FMT_BGRA8888: return 4;
            FMT_GRAY8:    return 1;
            default:      return 2;
        endcase
    endfunction

    // Unclamped raster byte address under the current shadow registers.
    // Width above MAX_WIDTH saturates; column is never checked against width.
    function automatic u64_t raster_addr(pix_t p);
        u64_t w, bx, by, idx, row, col;
        w   = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        bx  = p.block_x;
        by  = p.block_y;
        idx = p.pixel_index;
        row = by * BLOCK_SIDE + idx / BLOCK_SIDE;
        col = bx * BLOCK_SIDE + idx % BLOCK_SIDE;
        return (row * w + col) * bytes_per_pixel(fmt_reg);
    endfunction

    function automatic res_t pack_pixel(pix_t p);
        res_t r;
        u64_t lim, addr, n, cnt;
        n   = bytes_per_pixel(fmt_reg);
        lim = (bufsz_reg > ADDR_SPAN) ? ADDR_SPAN : bufsz_reg;
        r   = '0;
        case (fmt_reg)
            FMT_BGR888, FMT_BGRA8888:
            begin
                r.bytes[0] = p.blue;
                r.bytes[1] = p.green;
                r.bytes[2] = p.red_or_gray;
                if (fmt_reg == FMT_BGRA8888)
                    r.bytes[3] = p.alpha;
            end
            FMT_GRAY8:
                r.bytes[0] = p.red_or_gray;
            default:
            begin
                // 565 low byte: green low bits over the full blue byte (no mask)
                r.bytes[0] = {p.green[2:0], 5'b0} | p.blue;
                r.bytes[1] = {p.red_or_gray[4:0], p.green[5:3]};
            end
        endcase
        addr = raster_addr(p);
        if (addr >= lim)
        begin
            cnt  = 0;
            addr = 0;
        end
        else
        begin
            // trim a pixel that straddles the buffer end
            cnt = lim - addr;
            if (cnt > n)
                cnt = n;
        end
        for (int k = 0; k < 4; k++)
            if (k >= cnt)
                r.bytes[k] = '0;
        r.byte_address = addr[ADDR_W-1:0];
        r.byte_count   = cnt[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result sink: random stall, compare against oldest prediction
    // ------------------------------------------------------------------
    initial
    begin
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic check_field(string name, u64_t want, u64_t got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual addr 0x%0h count %0d",
                         $time, res_bus.byte_address, res_bus.byte_count);
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("byte_address", want.byte_address, res_bus.byte_address);
                check_field("byte_count",   want.byte_count,   res_bus.byte_count);
                check_field("out_byte0",    want.bytes[0],     res_bus.out_byte0);
                check_field("out_byte1",    want.bytes[1],     res_bus.out_byte1);
                check_field("out_byte2",    want.bytes[2],     res_bus.out_byte2);
                check_field("out_byte3",    want.bytes[3],     res_bus.out_byte3);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel source and register writes
    // ------------------------------------------------------------------

    // One pixel request; valid stays high on return so back-to-back
    // requests need no bubble. Prediction uses registers at accept time.
    task automatic send_pixel(pix_t p);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            pix_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.block_x     <= p.block_x;
        pix_bus.block_y     <= p.block_y;
        pix_bus.pixel_index <= p.pixel_index;
        pix_bus.red_or_gray <= p.red_or_gray;
        pix_bus.green       <= p.green;
        pix_bus.blue        <= p.blue;
        pix_bus.alpha       <= p.alpha;
        @(posedge clk);
        while (!pix_bus.ready)
            @(posedge clk);
        pending_pixels.push_back(pack_pixel(p));
    endtask

    // Source goes quiet until every prediction is matched and the pipe empties.
    task automatic drain_results();
        pix_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // Leaves valid high; caller drops it after the last write.
    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg = val[WIDTH_W-1:0];
            REG_PIXEL_FORMAT: fmt_reg   = fmt_t'(val[1:0]);
            REG_BUFFER_SIZE:  bufsz_reg = val[BUF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [WIDTH_W-1:0] w, fmt_t f, logic [BUF_W-1:0] sz);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, DATA_W'(w));
        write_reg(REG_PIXEL_FORMAT, DATA_W'(f));
        write_reg(REG_BUFFER_SIZE, DATA_W'(sz));
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic pix_t rand_pixel(int bx_hi, int by_hi);
        pix_t p;
        p.block_x     = COMP_W'($urandom_range(0, bx_hi));
        p.block_y     = COMP_W'($urandom_range(0, by_hi));
        p.pixel_index = COMP_W'($urandom_range(0, 255));
        p.red_or_gray = COMP_W'($urandom_range(0, 255));
        p.green       = COMP_W'($urandom_range(0, 255));
        p.blue        = COMP_W'($urandom_range(0, 255));
        p.alpha       = COMP_W'($urandom_range(0, 255));
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests. Pixel literals: {block_x, block_y, index, red, green, blue, alpha}
    // ------------------------------------------------------------------

    // Registers at reset: width 1, BGR888, empty buffer, so nothing lands.
    task automatic test_reset_defaults();
        send_pixel({8'd0, 8'd0, 8'd0, 8'h12, 8'h34, 8'h56, 8'h78});
        send_pixel({8'd7, 8'd3, 8'h4b, 8'hff, 8'h00, 8'hff, 8'h00});
    endtask

    // Largest width and buffer: the far corner pixel fills the last 4 bytes.
    task automatic test_extremes();
        set_config(13'd4096, FMT_BGRA8888, ADDR_SPAN);
        send_pixel({8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        send_pixel({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    endtask

    // Every pixel format; the first 565 pixel carries blue above five bits.
    task automatic test_formats();
        fmt_t f;
        for (int i = 0; i < 4; i++)
        begin
            f = fmt_t'(i);
            set_config(13'd64, f, 27'd1 << 20);
            send_pixel({8'd0, 8'd0, 8'd1, 8'ha5, 8'h3c, 8'hff, 8'h5a});
            send_pixel({8'd3, 8'd2, 8'h9e, 8'h1f, 8'hc3, 8'h0a, 8'hf0});
        end
    endtask

    // Buffer end: straddle, start exactly at the end, size above 2^26.
    task automatic test_buffer_edges();
        set_config(13'd16, FMT_BGRA8888, 27'd6);
        send_pixel({8'd0, 8'd0, 8'd1, 8'h11, 8'h22, 8'h33, 8'h44});   // 2 of 4 bytes
        send_pixel({8'd0, 8'd0, 8'd2, 8'h55, 8'h66, 8'h77, 8'h88});   // starts past end
        set_config(13'd16, FMT_BGRA8888, 27'd4);
        send_pixel({8'd0, 8'd0, 8'd1, 8'h99, 8'haa, 8'hbb, 8'hcc});   // starts at end
        set_config(13'd16, FMT_BGR888, 27'd7);
        send_pixel({8'd0, 8'd0, 8'd2, 8'hde, 8'had, 8'hbe, 8'hef});   // 1 of 3 bytes
        set_config(13'd4096, FMT_BGRA8888, {BUF_W{1'b1}});          // clamps to 2^26
        send_pixel({8'hff, 8'hff, 8'hff, 8'h01, 8'h02, 8'h04, 8'h08});
    endtask

    // Width above the maximum, width zero, column past the width, unused index.
    task automatic test_width_edges();
        set_config({WIDTH_W{1'b1}}, FMT_GRAY8, ADDR_SPAN);
        send_pixel({8'd1, 8'd1, 8'h11, 8'h80, 8'h40, 8'h20, 8'h10});
        set_config(13'd0, FMT_RGB565, ADDR_SPAN);
        send_pixel({8'd2, 8'd5, 8'h23, 8'h3f, 8'hf8, 8'h1f, 8'h00});
        send_pixel({8'd0, 8'd9, 8'hf0, 8'hc0, 8'h07, 8'he0, 8'hff});
        set_config(13'd20, FMT_BGR888, ADDR_SPAN);
        send_pixel({8'd3, 8'd0, 8'h05, 8'h0f, 8'hf0, 8'haa, 8'h55});
        // a write to the spare index must leave the live registers alone
        drain_results();
        write_reg(REG_UNUSED, {DATA_W{1'b1}});
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
        send_pixel({8'd3, 8'd0, 8'h06, 8'h0f, 8'hf0, 8'haa, 8'h55});
    endtask

    // Random settings per run of 60 pixels; one mid-run pause per phase.
    task automatic test_random(int idle, int stall, int count);
        logic [WIDTH_W-1:0] w;
        fmt_t               f;
        logic [BUF_W-1:0]   sz;
        int                 bx_hi, by_hi;
        pix_t               probe;
        drain_results();
        idle_pct  = idle;
        stall_pct = stall;
        for (int sent = 0; sent < count; sent++)
        begin
            if (sent % 60 == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       w = 13'd0;
                    1:       w = 13'd1;
                    2:       w = 13'd4096;
                    3:       w = WIDTH_W'($urandom_range(4097, 8191));
                    4:       w = WIDTH_W'($urandom_range(16, 64));
                    default: w = WIDTH_W'($urandom_range(1, 4096));
                endcase
                f = fmt_t'($urandom_range(0, 3));
                // small block range keeps addresses near the buffer end cases
                bx_hi = $urandom_range(0, 1) ? 255 : 3;
                by_hi = $urandom_range(0, 1) ? 255 : 3;
                drain_results();
                write_reg(REG_IMAGE_WIDTH, DATA_W'(w));
                write_reg(REG_PIXEL_FORMAT, DATA_W'(f));
                case ($urandom_range(0, 5))
                    0:       sz = '0;
                    1:       sz = ADDR_SPAN;
                    2:       sz = BUF_W'($urandom_range(32'h0400_0001, 32'h07ff_ffff));
                    3, 4:
                    begin
                        // end the buffer around one pixel of this run
                        probe = rand_pixel(bx_hi, by_hi);
                        sz = BUF_W'(raster_addr(probe) + $urandom_range(0, 4));
                    end
                    default: sz = BUF_W'($urandom_range(0, 32'h07ff_ffff));
                endcase
                write_reg(REG_BUFFER_SIZE, DATA_W'(sz));
                cfg_bus.valid <= 1'b0;
                @(posedge clk);
            end
            if (sent == count / 2 + 7)
                drain_results();
            send_pixel(rand_pixel(bx_hi, by_hi));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        idle_pct            = 0;
        stall_pct           = 0;
        width_reg           = 13'd1;
        fmt_reg             = FMT_BGR888;
        bufsz_reg           = '0;
        rst_n               = 1'b0;
        pix_bus.valid       = 1'b0;
        pix_bus.block_x     = '0;
        pix_bus.block_y     = '0;
        pix_bus.pixel_index = '0;
        pix_bus.red_or_gray = '0;
        pix_bus.green       = '0;
        pix_bus.blue        = '0;
        pix_bus.alpha       = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_IMAGE_WIDTH;
        cfg_bus.data        = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extremes();
        test_formats();
        test_buffer_edges();
        test_width_edges();

        test_random(0, 0, 360);      // full rate both ways
        test_random(67, 0, 360);     // sparse source
        test_random(0, 67, 360);     // slow sink, back-pressure
        test_random(16, 16, 360);    // light jitter on both sides

        drain_results();
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("tb_macroblock_raster_pixel_packer: done, clean");
        else
            $display("tb_macroblock_raster_pixel_packer: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mrp_pkg.sv
sv/mrp_ifs.sv
sv/mrp_cfg_regs.sv
sv/mrp_offset_stage.sv
sv/mrp_emit_stage.sv
sv/macroblock_raster_pixel_packer.sv
verif/tb_macroblock_raster_pixel_packer.sv
